@@ design/longest_decreasing_subsequence_count_core_macros.svh @@
// Assertion macros used by the checker file of the decreasing subsequence core.
// Each macro expects clk and arst_n in scope where it is used.
`ifndef LONGEST_DECREASING_SUBSEQUENCE_COUNT_CORE_MACROS_SVH
`define LONGEST_DECREASING_SUBSEQUENCE_COUNT_CORE_MACROS_SVH

// Checks a property on every rising edge of clk outside reset.
`define LDSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define LDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ldsc_pkg.sv @@
// Package for the decreasing subsequence core: widths, state type, control structs and a saturating add.
// Used by ldsc_acc, the top level, the checker and the testbench; depends on nothing.
package ldsc_pkg;

	localparam int unsigned MAX_ELEMENTS_DEF = 1024;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 32;
	localparam int OUT_LEN_W = 11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} ldsc_state_t;

	typedef struct packed {
		logic init;
		logic en;
	} acc_ctl_t;

	typedef struct packed {
		logic [COUNT_W-1:0] sum;
		logic sat;
	} sat_sum_t;

	function automatic sat_sum_t sat_add(input logic [COUNT_W-1:0] a, input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		sat_sum_t r;
		s = {1'b0, a} + {1'b0, b};
		r.sat = s[COUNT_W];
		r.sum = s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
		return r;
	endfunction

endpackage

@@ design/ldsc_mem.sv @@
// Single-port-write, single-port-read synchronous memory holding one entry per element.
// Read data is registered; depends on nothing.
module ldsc_mem #(
	parameter int DEPTH = 1024,
	parameter int DATA_W = 75,
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ design/ldsc_acc.sv @@
// Scan accumulator: folds each earlier element that is greater than the new one
// into the best length and its saturating count. Depends on ldsc_pkg.
module ldsc_acc
	import ldsc_pkg::*;
#(
	parameter int LEN_W = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  acc_ctl_t                   ctl,
	input  logic signed [VALUE_W-1:0]  key,
	input  logic signed [VALUE_W-1:0]  rd_value,
	input  logic        [LEN_W-1:0]    rd_len,
	input  logic        [COUNT_W-1:0]  rd_cnt,
	output logic        [LEN_W-1:0]    len,
	output logic        [COUNT_W-1:0]  cnt,
	output logic                       ovf
);

	logic [LEN_W-1:0]   len_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               ovf_q;
	logic [LEN_W-1:0]   cand;
	sat_sum_t           ss;

	assign cand = rd_len + LEN_W'(1);
	assign ss = sat_add(cnt_q, rd_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.init) begin
			len_q <= LEN_W'(1);
			cnt_q <= COUNT_W'(1);
			ovf_q <= 1'b0;
		end else if (ctl.en && (rd_value > key)) begin
			if (cand > len_q) begin
				len_q <= cand;
				cnt_q <= rd_cnt;
			end else if (cand == len_q) begin
				cnt_q <= ss.sum;
				ovf_q <= ovf_q | ss.sat;
			end
		end
	end

	assign len = len_q;
	assign cnt = cnt_q;
	assign ovf = ovf_q;

endmodule

@@ design/longest_decreasing_subsequence_count_core.sv @@
// Channel  Handshake           Payload
// in       in_valid, in_stall  value[31:0] signed, last
// out      out_valid, out_stall best_length[10:0], best_count[31:0], count_saturated
//
// An element passes through the accept state, one memory read per stored element, a drain
// state for the last read and a finish state. With nothing stored, or with the memory already
// full, an element goes from the accept state straight to the finish state.
// Reset clears the control state and the running results; the element memory is not cleared.
// A finished result waits in the output register while the next element is taken; a last
// element waits in its finish cycle only while an earlier result is still stalled.
// Top level of the decreasing subsequence core; depends on ldsc_pkg, ldsc_mem and ldsc_acc.
module longest_decreasing_subsequence_count_core
	import ldsc_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [VALUE_W-1:0]   value,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic        [OUT_LEN_W-1:0] best_length,
	output logic        [COUNT_W-1:0]   best_count,
	output logic                        count_saturated
);

	localparam int ADDR_W = $clog2(MAX_ELEMENTS);
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	localparam int LEN_W = CNT_W;
	localparam int ENTRY_W = VALUE_W + LEN_W + COUNT_W;

	ldsc_state_t state_q, state_next;

	logic signed [VALUE_W-1:0] value_q;
	logic                      last_q;
	logic [CNT_W-1:0]          count_q;
	logic [ADDR_W-1:0]         rd_idx_q;
	logic                      rd_v_s1;
	logic [LEN_W-1:0]          best_q;
	logic [COUNT_W-1:0]        total_q;
	logic                      ovf_q;
	logic                      out_valid_q;
	logic [LEN_W-1:0]          out_len_q;
	logic [COUNT_W-1:0]        out_cnt_q;
	logic                      out_sat_q;

	logic                      accept;
	logic                      stored;
	logic                      scan_end;
	logic                      can_emit;
	logic                      fin_go;
	acc_ctl_t                  acc_ctl;
	logic                      mem_we;
	logic [ENTRY_W-1:0]        wdata;
	logic [ENTRY_W-1:0]        rdata;
	logic [LEN_W-1:0]          acc_len;
	logic [COUNT_W-1:0]        acc_cnt;
	logic                      acc_ovf;
	logic [LEN_W-1:0]          best_next;
	logic [COUNT_W-1:0]        total_next;
	logic                      ovf_next;
	sat_sum_t                  ss;
	logic [LEN_W+OUT_LEN_W-1:0] len_ext;

	assign stored = count_q < CNT_W'(MAX_ELEMENTS);
	assign scan_end = CNT_W'(rd_idx_q) == (count_q - CNT_W'(1));
	assign can_emit = !out_valid_q || !out_stall;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = (stored && (count_q != '0)) ? ST_SCAN : ST_FIN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_next = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_next = ST_FIN;
			end
			ST_FIN: begin
				if (!last_q || can_emit) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		accept = (state_q == ST_IDLE) && in_valid;
		fin_go = (state_q == ST_FIN) && (!last_q || can_emit);
		acc_ctl.init = accept;
		acc_ctl.en = rd_v_s1;
		mem_we = fin_go && stored;
	end

	always_comb begin
		ss = sat_add(total_q, acc_cnt);
		best_next = best_q;
		total_next = total_q;
		ovf_next = ovf_q;
		if (stored) begin
			ovf_next = ovf_q | acc_ovf;
			if (acc_len > best_q) begin
				best_next = acc_len;
				total_next = acc_cnt;
			end else if (acc_len == best_q) begin
				total_next = ss.sum;
				ovf_next = ovf_q | acc_ovf | ss.sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_v_s1 <= 1'b0;
			best_q <= '0;
			total_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			rd_v_s1 <= (state_q == ST_SCAN);
			if (fin_go) begin
				if (last_q) begin
					count_q <= '0;
					best_q <= '0;
					total_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					count_q <= count_q + CNT_W'(stored);
					best_q <= best_next;
					total_q <= total_next;
					ovf_q <= ovf_next;
				end
			end
			if (fin_go && last_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
			last_q <= last;
			rd_idx_q <= '0;
		end else if (state_q == ST_SCAN) begin
			rd_idx_q <= rd_idx_q + ADDR_W'(1);
		end
		if (fin_go && last_q) begin
			out_len_q <= best_next;
			out_cnt_q <= total_next;
			out_sat_q <= ovf_next;
		end
	end

	assign wdata = {value_q, acc_len, acc_cnt};

	ldsc_mem #(
		.DEPTH (MAX_ELEMENTS),
		.DATA_W(ENTRY_W),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(wdata),
		.raddr(rd_idx_q),
		.rdata(rdata)
	);

	ldsc_acc #(
		.LEN_W(LEN_W)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (acc_ctl),
		.key     (value_q),
		.rd_value(rdata[ENTRY_W-1 -: VALUE_W]),
		.rd_len  (rdata[COUNT_W +: LEN_W]),
		.rd_cnt  (rdata[COUNT_W-1:0]),
		.len     (acc_len),
		.cnt     (acc_cnt),
		.ovf     (acc_ovf)
	);

	assign len_ext = {{OUT_LEN_W{1'b0}}, out_len_q};

	assign out_valid = out_valid_q;
	assign best_length = len_ext[OUT_LEN_W-1:0];
	assign best_count = out_cnt_q;
	assign count_saturated = out_sat_q;

endmodule

@@ design/ldsc_checker.sv @@
// Port-level checker for the decreasing subsequence core, bound to the top level.
// Depends on ldsc_pkg and the core's assertion macro header.
`include "longest_decreasing_subsequence_count_core_macros.svh"

module ldsc_checker
	import ldsc_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [OUT_LEN_W-1:0]      best_length,
	input logic [COUNT_W-1:0]        best_count,
	input logic                      count_saturated
);

	`LDSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "Stalled output word was dropped.")
	`LDSC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(best_length) && $stable(best_count) && $stable(count_saturated), "Stalled output word changed.")
	`LDSC_ASSERT(a_count_nonzero, out_valid |-> (best_count != '0), "Output word carries a zero count.")
	`LDSC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "Input taken again before the scan ran.")

endmodule

bind longest_decreasing_subsequence_count_core ldsc_checker u_ldsc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.best_length    (best_length),
	.best_count     (best_count),
	.count_saturated(count_saturated)
);

@@ test/testbench.sv @@
// Testbench for longest_decreasing_subsequence_count_core: queued stimulus, a driver, a monitor
// and a predictor of the subsequence length and count. Depends on ldsc_pkg and the core.
module testbench;
	import ldsc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef enum {
		STYLE_WIDE,
		STYLE_NARROW,
		STYLE_EDGE,
		STYLE_FALLING
	} value_style_e;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic last;
		bit hold;
		bit calm;
	} word_t;

	typedef struct {
		logic [OUT_LEN_W-1:0] best_len;
		logic [COUNT_W-1:0] best_cnt;
		logic sat;
	} tally_t;

	logic clk;
	logic arst_n;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [VALUE_W-1:0] value = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUT_LEN_W-1:0] best_length;
	logic [COUNT_W-1:0] best_count;
	logic count_saturated;

	word_t pending_words[$];
	word_t offered_word;
	tally_t expected_tallies[$];
	bit fill_hold = 1'b0;
	bit fill_calm = 1'b0;
	logic hold_off = 1'b0;
	logic quiet = 1'b0;
	int tx_gap = 0;
	int tx_lull = 0;
	int rx_burst = 0;
	int rx_lull = 0;
	int errors = 0;
	int results_seen = 0;

	logic signed [VALUE_W-1:0] seq_vals [MAX_ELEMENTS_DEF];
	logic [OUT_LEN_W-1:0] seq_lens [MAX_ELEMENTS_DEF];
	logic [COUNT_W-1:0] seq_cnts [MAX_ELEMENTS_DEF];
	int stored_n = 0;
	logic [OUT_LEN_W-1:0] run_len = '0;
	logic [COUNT_W-1:0] run_total = '0;
	logic model_sat = 1'b0;

	longest_decreasing_subsequence_count_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.best_length(best_length),
		.best_count(best_count),
		.count_saturated(count_saturated)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
	end

	function automatic logic [COUNT_W-1:0] clamp_add(input logic [COUNT_W-1:0] a,
		input logic [COUNT_W-1:0] b);
		logic [COUNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s[COUNT_W]) begin
			model_sat = 1'b1;
			return '1;
		end
		return s[COUNT_W-1:0];
	endfunction

	function automatic void track_element(input word_t w);
		logic [OUT_LEN_W-1:0] len;
		logic [OUT_LEN_W-1:0] cand;
		logic [COUNT_W-1:0] cnt;
		tally_t t;
		if (stored_n < MAX_ELEMENTS_DEF) begin
			len = OUT_LEN_W'(1);
			cnt = COUNT_W'(1);
			for (int j = 0; j < stored_n; j++) begin
				if (seq_vals[j] > w.value) begin
					cand = seq_lens[j] + 1'b1;
					if (cand > len) begin
						len = cand;
						cnt = seq_cnts[j];
					end else if (cand == len) begin
						cnt = clamp_add(cnt, seq_cnts[j]);
					end
				end
			end
			seq_vals[stored_n] = w.value;
			seq_lens[stored_n] = len;
			seq_cnts[stored_n] = cnt;
			stored_n++;
			if (len > run_len) begin
				run_len = len;
				run_total = cnt;
			end else if (len == run_len) begin
				run_total = clamp_add(run_total, cnt);
			end
		end
		if (w.last) begin
			t.best_len = run_len;
			t.best_cnt = run_total;
			t.sat = model_sat;
			expected_tallies.push_back(t);
			stored_n = 0;
			run_len = '0;
			run_total = '0;
			model_sat = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver
		word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			last <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				track_element(offered_word);
			if (tx_lull > 0)
				tx_lull--;
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_words[0].hold && expected_tallies.size() != 0) begin
					in_valid <= 1'b0;
				end else begin
					w = pending_words.pop_front();
					offered_word = w;
					in_valid <= 1'b1;
					value <= w.value;
					last <= w.last;
					quiet <= w.calm;
					if (!w.calm && tx_lull == 0) begin
						if ($urandom_range(0, 49) == 0)
							tx_lull = $urandom_range(30, 150);
						else if ($urandom_range(0, 6) == 0)
							tx_gap = $urandom_range(1, 6);
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		tally_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (expected_tallies.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected word, expected none, got length %0d count %0d sat %0b",
						$time, best_length, best_count, count_saturated);
				end else begin
					e = expected_tallies.pop_front();
					if (best_length !== e.best_len) begin
						errors++;
						$display("%0t ns: best_length expected %0d, got %0d",
							$time, e.best_len, best_length);
					end
					if (best_count !== e.best_cnt) begin
						errors++;
						$display("%0t ns: best_count expected %0d, got %0d",
							$time, e.best_cnt, best_count);
					end
					if (count_saturated !== e.sat) begin
						errors++;
						$display("%0t ns: count_saturated expected %0b, got %0b",
							$time, e.sat, count_saturated);
					end
				end
			end
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (quiet || rx_lull > 0) begin
				if (rx_lull > 0)
					rx_lull--;
				out_stall <= 1'b0;
			end else if (rx_burst > 0) begin
				rx_burst--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				rx_burst = $urandom_range(0, 5);
				out_stall <= 1'b1;
			end else begin
				if ($urandom_range(0, 59) == 0)
					rx_lull = $urandom_range(30, 150);
				out_stall <= 1'b0;
			end
		end
	end

	// The receiver holds off long enough for the core to fill and stall its input.
	initial begin
		wait (results_seen >= 12);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#200_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic add_word(input logic signed [VALUE_W-1:0] v, input logic l);
		word_t w;
		w.value = v;
		w.last = l;
		w.hold = fill_hold;
		w.calm = fill_calm;
		fill_hold = 1'b0;
		pending_words.push_back(w);
	endtask

	task automatic add_sequence(input int n, input value_style_e style);
		logic signed [VALUE_W-1:0] walk;
		logic signed [VALUE_W-1:0] v;
		walk = $urandom;
		for (int i = 0; i < n; i++) begin
			case (style)
				STYLE_WIDE: begin
					v = $urandom;
				end
				STYLE_NARROW: begin
					v = $signed($urandom_range(0, 15)) - 8;
				end
				STYLE_EDGE: begin
					case ($urandom_range(0, 4))
						0: v = 32'sh8000_0000;
						1: v = 32'sh7FFF_FFFF;
						2: v = 0;
						3: v = -1;
						default: v = 1;
					endcase
				end
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						v = walk + $signed($urandom_range(0, 7));
					end else begin
						walk = walk - $signed($urandom_range(0, 3));
						v = walk;
					end
				end
			endcase
			add_word(v, i == n - 1);
		end
	endtask

	initial begin
		int random_words;
		int n;
		int r;
		bit overlong_done;
		logic signed [VALUE_W-1:0] walk;

		add_word(32'sh7FFF_FFFF, 1'b1);
		add_word(32'sh8000_0000, 1'b1);
		add_word(32'sh7FFF_FFFF, 1'b0);
		add_word(32'sh8000_0000, 1'b1);
		add_word(32'sh8000_0000, 1'b0);
		add_word(32'sh7FFF_FFFF, 1'b1);
		add_word(5, 1'b0);
		add_word(5, 1'b0);
		add_word(5, 1'b1);
		add_word(3, 1'b0);
		add_word(2, 1'b0);
		add_word(1, 1'b1);
		add_word(3, 1'b0);
		add_word(1, 1'b0);
		add_word(2, 1'b0);
		add_word(0, 1'b1);
		add_word(-1, 1'b0);
		add_word(0, 1'b0);
		add_word(-1, 1'b0);
		add_word(-2, 1'b1);

		// Equal pairs on each level double the count until it saturates.
		fill_hold = 1'b1;
		for (int i = 0; i < 34; i++) begin
			add_word(1000 - i, 1'b0);
			add_word(1000 - i, i == 33);
		end

		random_words = 0;
		overlong_done = 1'b0;
		while (random_words < 580) begin
			if (!overlong_done && random_words >= 300) begin
				fill_hold = 1'b1;
				walk = 32'sh7FFF_FFFF;
				for (int i = 0; i < MAX_ELEMENTS_DEF; i++) begin
					add_word(walk, 1'b0);
					walk = walk - $signed($urandom_range(1, 1 << 20));
				end
				for (int i = 0; i < 6; i++)
					add_word($urandom, i == 5);
				overlong_done = 1'b1;
			end
			fill_calm = (random_words >= 520);
			if (random_words >= 150 && $urandom_range(0, 14) == 0)
				fill_hold = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 80)
				n = $urandom_range(1, 12);
			else if (r < 95)
				n = $urandom_range(13, 40);
			else
				n = $urandom_range(41, 120);
			add_sequence(n, value_style_e'($urandom_range(0, 3)));
			random_words += n;
		end

		while (pending_words.size() != 0 || in_valid || expected_tallies.size() != 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);
		if (errors == 0 && expected_tallies.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
